@@ hdl/wstd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wstd_pkg
// Shared sizes, codes and item types of the work stealing task dispatcher.
// ----------------------------------------------------------------------------
package wstd_pkg;

  localparam int MAX_WORKERS = 8;
  localparam int STACK_DEPTH = 256;
  localparam int STORE_DEPTH = 256;
  localparam int GROUP_SLOTS = 8;

  localparam int WRK_W   = $clog2(MAX_WORKERS);
  localparam int SIDX_W  = $clog2(STACK_DEPTH);
  localparam int SAW     = $clog2(STORE_DEPTH);
  localparam int CNT_W   = SAW + 1;
  localparam int HGT_W   = SIDX_W + 1;
  localparam int GS_AW   = $clog2(GROUP_SLOTS);
  localparam int GS_CW   = GS_AW + 1;
  localparam int CFG_W   = 4;
  localparam int TASK_W  = 16;
  localparam int TAG_W   = 8;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_SUBMIT = 2'd1,
    ACT_FETCH  = 2'd2,
    ACT_FINISH = 2'd3
  } action_e;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_STORE_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY_GROUP = 2'd2;
  localparam logic [1:0] ST_QUEUE_FULL  = 2'd3;

  typedef struct packed {
    action_e             action;
    logic [TASK_W-1:0]   task_id;
    logic [2:0]          worker;
  } cmd_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                task_valid;
    logic [TASK_W-1:0]   task_out;
    logic                stole;
    logic [TAG_W-1:0]    submitted_tag;
    logic                group_done;
    logic [TAG_W-1:0]    done_tag;
  } res_t;

endpackage

@@ hdl/wstd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wstd_front
// Command intake: decode the item into a command and queue it (two deep).
// ----------------------------------------------------------------------------
module wstd_front import wstd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] action_i,
  input  logic [15:0] task_id_i,
  input  logic [2:0] worker_i,
  output logic       busy_o,
  input  logic       pop_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o
);

  cmd_t       q_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign busy_o      = (cnt_q == 2'd2);
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= '{action: action_e'(action_i), task_id: task_id_i, worker: worker_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

endmodule

@@ hdl/wstd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wstd_back
// Command execution: task store, group queue, worker stacks, steals.
// ----------------------------------------------------------------------------
module wstd_back import wstd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  output logic             res_valid_o,
  output res_t             res_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EXEC = 4'd1;
  localparam logic [3:0] S_ACT  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_PER  = 4'd4;
  localparam logic [3:0] S_DRD  = 4'd5;
  localparam logic [3:0] S_DWR  = 4'd6;
  localparam logic [3:0] S_SRD  = 4'd7;
  localparam logic [3:0] S_SWR  = 4'd8;
  localparam logic [3:0] S_POP  = 4'd9;
  localparam logic [3:0] S_PRD  = 4'd10;

  localparam logic [HGT_W-1:0] STACK_FULL = HGT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] STORE_FULL = CNT_W'(STORE_DEPTH);
  localparam logic [GS_CW-1:0] SLOTS      = GS_CW'(GROUP_SLOTS);
  localparam logic [CFG_W-1:0] MAXW       = CFG_W'(MAX_WORKERS);

  logic [3:0]        state_q;
  cmd_t              cmd_q;
  res_t              res_q;
  logic              res_valid_q;
  logic [CFG_W-1:0]  cfg_q;
  logic [SAW-1:0]    build_start_q;
  logic [CNT_W-1:0]  build_count_q, store_used_q;
  logic [SAW-1:0]    g_start_q [GROUP_SLOTS];
  logic [CNT_W-1:0]  g_count_q [GROUP_SLOTS];
  logic [TAG_W-1:0]  g_tag_q   [GROUP_SLOTS];
  logic [GS_AW-1:0]  head_q;
  logic [GS_CW-1:0]  gcnt_q;
  logic [TAG_W-1:0]  next_tag_q, active_tag_q;
  logic              active_q;
  logic [CNT_W-1:0]  rem_q;
  logic [HGT_W-1:0]  height_q [MAX_WORKERS];
  logic [SAW-1:0]    act_start_q;
  logic [CNT_W-1:0]  act_count_q, k_q, dq_q, chunk_q;
  logic [CFG_W-1:0]  divr_q, it_q;
  logic [WRK_W-1:0]  w_q, vic_q;
  logic [HGT_W-1:0]  sk_q, send_q;

  logic [TASK_W-1:0] store_mem [STORE_DEPTH];
  logic [TASK_W-1:0] stack_mem [MAX_WORKERS*STACK_DEPTH];
  logic [TASK_W-1:0] st_rdata_q, sk_rdata_q;

  logic [CFG_W-1:0]        nw;
  logic                    st_we, sk_we;
  logic [SAW-1:0]          st_waddr, st_raddr;
  logic [WRK_W+SIDX_W-1:0] sk_waddr, sk_raddr;
  logic [TASK_W-1:0]       sk_wdata;
  logic                    found;
  logic [WRK_W-1:0]        vic;
  logic [HGT_W-1:0]        vic_h, steal_n;
  logic [CFG_W:0]          div_t;
  logic                    div_ge;
  logic [CNT_W-1:0]        rem_dec;
  logic [GS_AW-1:0]        tail;

  always_comb begin
    if (cfg_q == '0) nw = CFG_W'(1);
    else if (cfg_q > MAXW) nw = MAXW;
    else nw = cfg_q;
  end

  // Lowest-indexed other worker that holds a task.
  always_comb begin
    found = 1'b0;
    vic   = '0;
    vic_h = '0;
    for (int v = 0; v < MAX_WORKERS; v++) begin
      if (!found && (CFG_W'(v) < nw) && (WRK_W'(v) != cmd_q.worker) &&
          (height_q[v] != '0)) begin
        found = 1'b1;
        vic   = WRK_W'(v);
        vic_h = height_q[v];
      end
    end
  end

  assign steal_n = (vic_h[HGT_W-1:1] == '0) ? HGT_W'(1) : {1'b0, vic_h[HGT_W-1:1]};
  assign div_t   = {divr_q, dq_q[CNT_W-1]};
  assign div_ge  = (div_t >= {1'b0, nw});
  assign rem_dec = (rem_q != '0) ? rem_q - CNT_W'(1) : rem_q;
  assign tail    = head_q + gcnt_q[GS_AW-1:0];

  assign st_we    = (state_q == S_EXEC) && (cmd_q.action == ACT_ADD) &&
                    (store_used_q < STORE_FULL);
  assign st_waddr = build_start_q + build_count_q[SAW-1:0];
  assign st_raddr = act_start_q + k_q[SAW-1:0];

  always_comb begin
    sk_we    = 1'b0;
    sk_waddr = {w_q, height_q[w_q][SIDX_W-1:0]};
    sk_wdata = st_rdata_q;
    if (state_q == S_DWR) begin
      sk_we = (height_q[w_q] < STACK_FULL);
    end else if (state_q == S_SWR) begin
      sk_we    = 1'b1;
      sk_waddr = {cmd_q.worker, height_q[cmd_q.worker][SIDX_W-1:0]};
      sk_wdata = sk_rdata_q;
    end
    if (state_q == S_SRD) sk_raddr = {vic_q, sk_q[SIDX_W-1:0]};
    else sk_raddr = {cmd_q.worker, height_q[cmd_q.worker][SIDX_W-1:0] - SIDX_W'(1)};
  end

  always_ff @(posedge clk_i) begin
    if (st_we) store_mem[st_waddr] <= cmd_q.task_id;
    st_rdata_q <= store_mem[st_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sk_we) stack_mem[sk_waddr] <= sk_wdata;
    sk_rdata_q <= stack_mem[sk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_EXEC) && (cmd_q.action == ACT_SUBMIT) && (build_count_q != '0) &&
        (gcnt_q < SLOTS)) begin
      g_start_q[tail] <= build_start_q;
      g_count_q[tail] <= build_count_q;
      g_tag_q[tail]   <= next_tag_q;
    end
  end

  assign cmd_pop_o   = (state_q == S_IDLE) && cmd_valid_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cmd_q         <= '0;
      res_q         <= '0;
      res_valid_q   <= 1'b0;
      cfg_q         <= MAXW;
      build_start_q <= '0;
      build_count_q <= '0;
      store_used_q  <= '0;
      head_q        <= '0;
      gcnt_q        <= '0;
      next_tag_q    <= '0;
      active_tag_q  <= '0;
      active_q      <= 1'b0;
      rem_q         <= '0;
      for (int i = 0; i < MAX_WORKERS; i++) height_q[i] <= '0;
      act_start_q   <= '0;
      act_count_q   <= '0;
      k_q           <= '0;
      dq_q          <= '0;
      chunk_q       <= '0;
      divr_q        <= '0;
      it_q          <= '0;
      w_q           <= '0;
      vic_q         <= '0;
      sk_q          <= '0;
      send_q        <= '0;
    end else begin
      res_valid_q <= 1'b0;
      if (cfg_we_i) cfg_q <= cfg_data_i;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            res_q   <= '0;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cmd_q.action)
            ACT_ADD: begin
              if (store_used_q >= STORE_FULL) begin
                res_q.status <= ST_STORE_FULL;
              end else begin
                build_count_q <= build_count_q + CNT_W'(1);
                store_used_q  <= store_used_q + CNT_W'(1);
              end
              res_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end
            ACT_SUBMIT: begin
              if (build_count_q == '0) begin
                res_q.status <= ST_EMPTY_GROUP;
                res_valid_q  <= 1'b1;
                state_q      <= S_IDLE;
              end else if (gcnt_q >= SLOTS) begin
                res_q.status <= ST_QUEUE_FULL;
                res_valid_q  <= 1'b1;
                state_q      <= S_IDLE;
              end else begin
                gcnt_q              <= gcnt_q + GS_CW'(1);
                res_q.submitted_tag <= next_tag_q;
                next_tag_q          <= next_tag_q + TAG_W'(1);
                build_start_q       <= build_start_q + build_count_q[SAW-1:0];
                build_count_q       <= '0;
                if (!active_q) begin
                  state_q <= S_ACT;
                end else begin
                  res_valid_q <= 1'b1;
                  state_q     <= S_IDLE;
                end
              end
            end
            ACT_FETCH: begin
              if ({1'b0, cmd_q.worker} >= nw) begin
                res_valid_q <= 1'b1;
                state_q     <= S_IDLE;
              end else if (height_q[cmd_q.worker] == '0) begin
                if (found) begin
                  res_q.stole   <= 1'b1;
                  vic_q         <= vic;
                  sk_q          <= vic_h - steal_n;
                  send_q        <= vic_h;
                  height_q[vic] <= vic_h - steal_n;
                  state_q       <= S_SRD;
                end else begin
                  res_valid_q <= 1'b1;
                  state_q     <= S_IDLE;
                end
              end else begin
                state_q <= S_POP;
              end
            end
            ACT_FINISH: begin
              if (active_q) begin
                rem_q <= rem_dec;
                if (rem_dec == '0) begin
                  res_q.group_done <= 1'b1;
                  res_q.done_tag   <= active_tag_q;
                  active_q         <= 1'b0;
                  state_q          <= S_ACT;
                end else begin
                  res_valid_q <= 1'b1;
                  state_q     <= S_IDLE;
                end
              end else begin
                res_valid_q <= 1'b1;
                state_q     <= S_IDLE;
              end
            end
            default: begin
              res_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end
          endcase
        end
        // Pop the oldest group, if one is queued, and start the chunk size division.
        S_ACT: begin
          if (gcnt_q == '0) begin
            active_q    <= 1'b0;
            res_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            act_start_q  <= g_start_q[head_q];
            act_count_q  <= g_count_q[head_q];
            active_tag_q <= g_tag_q[head_q];
            rem_q        <= g_count_q[head_q];
            dq_q         <= g_count_q[head_q];
            store_used_q <= store_used_q - g_count_q[head_q];
            head_q       <= head_q + GS_AW'(1);
            gcnt_q       <= gcnt_q - GS_CW'(1);
            active_q     <= 1'b1;
            divr_q       <= '0;
            it_q         <= '0;
            state_q      <= S_DIV;
          end
        end
        S_DIV: begin
          divr_q <= div_ge ? CFG_W'(div_t - {1'b0, nw}) : div_t[CFG_W-1:0];
          dq_q   <= {dq_q[CNT_W-2:0], div_ge};
          it_q   <= it_q + CFG_W'(1);
          if (it_q == CFG_W'(CNT_W - 1)) state_q <= S_PER;
        end
        S_PER: begin
          if (dq_q == '0) dq_q <= CNT_W'(1);
          k_q     <= '0;
          w_q     <= '0;
          chunk_q <= '0;
          state_q <= S_DRD;
        end
        S_DRD: begin
          state_q <= S_DWR;
        end
        S_DWR: begin
          if (height_q[w_q] < STACK_FULL) height_q[w_q] <= height_q[w_q] + HGT_W'(1);
          if ((chunk_q + CNT_W'(1) == dq_q) && ({1'b0, w_q} < nw - CFG_W'(1))) begin
            w_q     <= w_q + WRK_W'(1);
            chunk_q <= '0;
          end else begin
            chunk_q <= chunk_q + CNT_W'(1);
          end
          k_q <= k_q + CNT_W'(1);
          if (k_q + CNT_W'(1) == act_count_q) begin
            res_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_DRD;
          end
        end
        S_SRD: begin
          state_q <= S_SWR;
        end
        S_SWR: begin
          height_q[cmd_q.worker] <= height_q[cmd_q.worker] + HGT_W'(1);
          sk_q <= sk_q + HGT_W'(1);
          if (sk_q + HGT_W'(1) == send_q) state_q <= S_POP;
          else state_q <= S_SRD;
        end
        S_POP: begin
          height_q[cmd_q.worker] <= height_q[cmd_q.worker] - HGT_W'(1);
          state_q <= S_PRD;
        end
        S_PRD: begin
          res_q.task_valid <= 1'b1;
          res_q.task_out   <= sk_rdata_q;
          res_valid_q      <= 1'b1;
          state_q          <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/work_stealing_task_dispatcher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// work_stealing_task_dispatcher
// Collects task ids into groups, spreads each active group over per-worker
// LIFO stacks and serves worker fetches, stealing from a busy neighbor.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  command   start_i / busy_o          action_i, task_id_i, worker_i
//  config    cfg_we_i                  cfg_data_i (workers_in_use)
//  result    res_valid_o (strobe)      status_o .. done_tag_o
//
//  Add, submit and finish without activation give their result from the
//  execution state; a plain fetch first pops and reads its stack. Activating
//  a group pops the group queue, runs the chunk division (9 divide steps)
//  and a setup step, then does one store read and one stack write per task;
//  a steal does one stack read and one stack write per copied entry. Each
//  memory has one registered read port. Reset empties every stack and the
//  group queue at once. The intake queue holds two commands; busy_o rises
//  when it is full. Results cannot be held off and show for one cycle each.
// ----------------------------------------------------------------------------
module work_stealing_task_dispatcher import wstd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] task_id_i,
  input  logic [2:0]  worker_i,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_data_i,
  output logic        res_valid_o,
  output logic [1:0]  status_o,
  output logic        task_valid_o,
  output logic [15:0] task_out_o,
  output logic        stole_o,
  output logic [7:0]  submitted_tag_o,
  output logic        group_done_o,
  output logic [7:0]  done_tag_o
);

  cmd_t cmd;
  logic cmd_valid, cmd_pop;
  res_t res;

  // Intake: decode and queue commands.
  wstd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .action_i    (action_i),
    .task_id_i   (task_id_i),
    .worker_i    (worker_i),
    .busy_o      (busy_o),
    .pop_i       (cmd_pop),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  // Execution: one command at a time, memories and stack heights live here.
  wstd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid_o),
    .res_o       (res)
  );

  assign status_o        = res.status;
  assign task_valid_o    = res.task_valid;
  assign task_out_o      = res.task_out;
  assign stole_o         = res.stole;
  assign submitted_tag_o = res.submitted_tag;
  assign group_done_o    = res.group_done;
  assign done_tag_o      = res.done_tag;

endmodule

@@ hdl/wstd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wstd_checker
// Port-level checks on the result channel of the dispatcher.
// ----------------------------------------------------------------------------
module wstd_checker import wstd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_o,
  input logic [1:0]  status_o,
  input logic        task_valid_o,
  input logic [15:0] task_out_o,
  input logic        stole_o,
  input logic [7:0]  submitted_tag_o,
  input logic        group_done_o
);

  // A steal always yields a task.
  a_steal_gives_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && stole_o |-> task_valid_o) else $error("steal without task");

  a_no_task_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !task_valid_o |-> task_out_o == 16'd0) else $error("stray task id");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o != ST_OK |-> submitted_tag_o == 8'd0 && !group_done_o)
    else $error("error result carries data");

  // The execution unit returns to idle between commands, so results never come back to back.
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o) else $error("results back to back");

endmodule

bind work_stealing_task_dispatcher wstd_checker u_wstd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_o     (res_valid_o),
  .status_o        (status_o),
  .task_valid_o    (task_valid_o),
  .task_out_o      (task_out_o),
  .stole_o         (stole_o),
  .submitted_tag_o (submitted_tag_o),
  .group_done_o    (group_done_o)
);
